@@ hdl/bmhpq_pkg.sv @@
// ----------------------------------------------------------------------------
// bmhpq_pkg
// Shared types and constants for the binary max-heap priority queue.
// ----------------------------------------------------------------------------
package bmhpq_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int FUNC_W = 2;
    localparam int PRIO_W = 16;
    localparam int KEY_W  = 16;
    localparam int POS_W  = 6;
    localparam int STAT_W = 2;
    localparam int HELD_W = 7;

    typedef enum logic [FUNC_W-1:0] {
        FN_ENQ = 2'd0,
        FN_DEQ = 2'd1,
        FN_CHG = 2'd2,
        FN_NOP = 2'd3
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_CMP,
        S_DQ_LD,
        S_CH_LD,
        S_FIN,
        S_DONE
    } t_state;

    // read address selection for the two memory read ports
    typedef enum logic [2:0] {
        RD_NONE,
        RD_DEQ,
        RD_POS,
        RD_PARENT,
        RD_CHILD
    } t_rd_sel;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [KEY_W-1:0]  key;
    } t_entry;

    typedef struct packed {
        logic    cap;
        logic    enq_init;
        t_rd_sel rd_sel;
        logic    dq_load;
        logic    ch_load;
        logic    up_move;
        logic    dn_move;
        logic    fin_write;
        logic    err;
        t_status err_code;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        t_func func;
        logic  full;
        logic  empty;
        logic  pos_bad;
        logic  at_root;
        logic  up_stop;
        logic  child_out;
        logic  dn_stop;
        logic  pr_rise;
        logic  pr_fall;
    } t_flags;

endpackage

@@ hdl/bmhpq_ctrl.sv @@
// ----------------------------------------------------------------------------
// bmhpq_ctrl
// Sequencer for enqueue, dequeue and change-priority with sift up/down loops.
// ----------------------------------------------------------------------------
module bmhpq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  bmhpq_pkg::t_flags i_flags,
    output bmhpq_pkg::t_cmd   o_cmd
);

    bmhpq_pkg::t_state r_state, n_state;
    logic              r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bmhpq_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bmhpq_pkg::S_IDLE: begin
                if (i_in_valid) n_state = bmhpq_pkg::S_DECODE;
            end
            bmhpq_pkg::S_DECODE: begin
                unique case (i_flags.func)
                    bmhpq_pkg::FN_ENQ: n_state = i_flags.full ? bmhpq_pkg::S_DONE
                                                              : bmhpq_pkg::S_UP_RD;
                    bmhpq_pkg::FN_DEQ: n_state = i_flags.empty ? bmhpq_pkg::S_DONE
                                                               : bmhpq_pkg::S_DQ_LD;
                    bmhpq_pkg::FN_CHG: n_state = i_flags.pos_bad ? bmhpq_pkg::S_DONE
                                                                 : bmhpq_pkg::S_CH_LD;
                    bmhpq_pkg::FN_NOP: n_state = bmhpq_pkg::S_DONE;
                    default:           n_state = bmhpq_pkg::S_DONE;
                endcase
            end
            bmhpq_pkg::S_UP_RD: begin
                n_state = i_flags.at_root ? bmhpq_pkg::S_FIN : bmhpq_pkg::S_UP_CMP;
            end
            bmhpq_pkg::S_UP_CMP: begin
                n_state = i_flags.up_stop ? bmhpq_pkg::S_FIN : bmhpq_pkg::S_UP_RD;
            end
            bmhpq_pkg::S_DN_RD: begin
                n_state = i_flags.child_out ? bmhpq_pkg::S_FIN : bmhpq_pkg::S_DN_CMP;
            end
            bmhpq_pkg::S_DN_CMP: begin
                n_state = i_flags.dn_stop ? bmhpq_pkg::S_FIN : bmhpq_pkg::S_DN_RD;
            end
            bmhpq_pkg::S_DQ_LD: n_state = bmhpq_pkg::S_DN_RD;
            bmhpq_pkg::S_CH_LD: begin
                priority if (i_flags.pr_rise) n_state = bmhpq_pkg::S_UP_RD;
                else if (i_flags.pr_fall)     n_state = bmhpq_pkg::S_DN_RD;
                else                          n_state = bmhpq_pkg::S_DONE;
            end
            bmhpq_pkg::S_FIN:  n_state = bmhpq_pkg::S_DONE;
            bmhpq_pkg::S_DONE: begin
                if (!r_out_valid || !i_out_stall) n_state = bmhpq_pkg::S_IDLE;
            end
            default: n_state = bmhpq_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.rd_sel   = bmhpq_pkg::RD_NONE;
        o_cmd.err_code = bmhpq_pkg::ST_OK;
        unique case (r_state)
            bmhpq_pkg::S_IDLE: o_cmd.cap = i_in_valid;
            bmhpq_pkg::S_DECODE: begin
                unique case (i_flags.func)
                    bmhpq_pkg::FN_ENQ: begin
                        if (i_flags.full) begin
                            o_cmd.err      = 1'b1;
                            o_cmd.err_code = bmhpq_pkg::ST_FULL;
                        end else begin
                            o_cmd.enq_init = 1'b1;
                        end
                    end
                    bmhpq_pkg::FN_DEQ: begin
                        if (i_flags.empty) begin
                            o_cmd.err      = 1'b1;
                            o_cmd.err_code = bmhpq_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.rd_sel = bmhpq_pkg::RD_DEQ;
                        end
                    end
                    bmhpq_pkg::FN_CHG: begin
                        if (i_flags.pos_bad) begin
                            o_cmd.err      = 1'b1;
                            o_cmd.err_code = bmhpq_pkg::ST_BADPOS;
                        end else begin
                            o_cmd.rd_sel = bmhpq_pkg::RD_POS;
                        end
                    end
                    bmhpq_pkg::FN_NOP: o_cmd.err = 1'b0;
                    default:           o_cmd.err = 1'b0;
                endcase
            end
            bmhpq_pkg::S_UP_RD: begin
                if (!i_flags.at_root) o_cmd.rd_sel = bmhpq_pkg::RD_PARENT;
            end
            bmhpq_pkg::S_UP_CMP: o_cmd.up_move = !i_flags.up_stop;
            bmhpq_pkg::S_DN_RD: begin
                if (!i_flags.child_out) o_cmd.rd_sel = bmhpq_pkg::RD_CHILD;
            end
            bmhpq_pkg::S_DN_CMP: o_cmd.dn_move   = !i_flags.dn_stop;
            bmhpq_pkg::S_DQ_LD:  o_cmd.dq_load   = 1'b1;
            bmhpq_pkg::S_CH_LD:  o_cmd.ch_load   = 1'b1;
            bmhpq_pkg::S_FIN:    o_cmd.fin_write = 1'b1;
            bmhpq_pkg::S_DONE:   o_cmd.out_load  = !r_out_valid || !i_out_stall;
            default:             o_cmd.cap       = 1'b0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load)    n_out_valid = 1'b1;
        else if (!i_out_stall) n_out_valid = 1'b0;
    end

    assign o_in_stall  = (r_state != bmhpq_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ hdl/bmhpq_dp.sv @@
// ----------------------------------------------------------------------------
// bmhpq_dp
// Heap memory, moving-entry registers, index arithmetic and result registers.
// ----------------------------------------------------------------------------
module bmhpq_dp #(
    parameter int CAPACITY = bmhpq_pkg::CAPACITY_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bmhpq_pkg::t_cmd              i_cmd,
    output bmhpq_pkg::t_flags            o_flags,
    input  logic [bmhpq_pkg::FUNC_W-1:0] i_func,
    input  logic [bmhpq_pkg::PRIO_W-1:0] i_priority_in,
    input  logic [bmhpq_pkg::KEY_W-1:0]  i_key_in,
    input  logic [bmhpq_pkg::POS_W-1:0]  i_position,
    output logic [bmhpq_pkg::KEY_W-1:0]  o_key_out,
    output logic [bmhpq_pkg::PRIO_W-1:0] o_priority_out,
    output logic [bmhpq_pkg::STAT_W-1:0] o_status,
    output logic [bmhpq_pkg::HELD_W-1:0] o_entries_held
);

    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int CIW = AW + 2;
    localparam int PCW = (CW > bmhpq_pkg::POS_W) ? CW : bmhpq_pkg::POS_W;

    bmhpq_pkg::t_entry r_mem [CAPACITY];
    bmhpq_pkg::t_entry r_rd_a, r_rd_b;

    logic [CW-1:0]  r_cnt;
    logic [AW-1:0]  r_at;
    logic [bmhpq_pkg::PRIO_W-1:0] r_pr, r_in_prio;
    logic [bmhpq_pkg::KEY_W-1:0]  r_ky, r_in_key;
    logic [bmhpq_pkg::POS_W-1:0]  r_pos;
    bmhpq_pkg::t_func   r_func;

    logic [bmhpq_pkg::KEY_W-1:0]  r_res_key, r_o_key;
    logic [bmhpq_pkg::PRIO_W-1:0] r_res_pr, r_o_pr;
    bmhpq_pkg::t_status           r_res_st, r_o_st;
    logic [bmhpq_pkg::HELD_W-1:0] r_o_held;

    logic [AW-1:0]  w_at_m1, w_parent, w_last, w_sel_idx;
    logic [CIW-1:0] w_child, w_child1, w_cnt_x;
    logic           w_right_take;
    bmhpq_pkg::t_entry w_sel;

    logic [AW-1:0]     w_addr_a, w_addr_b, w_wr_addr;
    logic              w_wr_en;
    bmhpq_pkg::t_entry w_wr_data;

    // index arithmetic
    assign w_at_m1   = r_at - 1'b1;
    assign w_parent  = AW'(w_at_m1 >> 1);
    assign w_last    = AW'(r_cnt - 1'b1);
    assign w_child   = {1'b0, r_at, 1'b1};
    assign w_child1  = w_child + 1'b1;
    assign w_cnt_x   = CIW'(r_cnt);

    // right child wins only if strictly larger
    assign w_right_take = (w_child1 < w_cnt_x) && (r_rd_a.prio < r_rd_b.prio);
    assign w_sel        = w_right_take ? r_rd_b : r_rd_a;
    assign w_sel_idx    = w_right_take ? w_child1[AW-1:0] : w_child[AW-1:0];

    always_comb begin
        w_addr_a = '0;
        w_addr_b = '0;
        unique case (i_cmd.rd_sel)
            bmhpq_pkg::RD_NONE:   w_addr_a = '0;
            bmhpq_pkg::RD_DEQ:    w_addr_b = w_last;
            bmhpq_pkg::RD_POS:    w_addr_a = AW'(r_pos);
            bmhpq_pkg::RD_PARENT: w_addr_a = w_parent;
            bmhpq_pkg::RD_CHILD: begin
                w_addr_a = w_child[AW-1:0];
                w_addr_b = w_child1[AW-1:0];
            end
            default:              w_addr_a = '0;
        endcase
    end

    always_comb begin
        w_wr_en   = i_cmd.up_move || i_cmd.dn_move || i_cmd.fin_write;
        w_wr_addr = r_at;
        priority if (i_cmd.up_move) w_wr_data = r_rd_a;
        else if (i_cmd.dn_move)     w_wr_data = w_sel;
        else                        w_wr_data = '{prio: r_pr, key: r_ky};
    end

    // heap memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (w_wr_en) r_mem[w_wr_addr] <= w_wr_data;
        r_rd_a <= r_mem[w_addr_a];
        r_rd_b <= r_mem[w_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.enq_init) begin
            r_cnt <= r_cnt + 1'b1;
        end else if (i_cmd.dq_load) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_func    <= bmhpq_pkg::t_func'(i_func);
            r_in_prio <= i_priority_in;
            r_in_key  <= i_key_in;
            r_pos     <= i_position;
            r_res_key <= '0;
            r_res_pr  <= '0;
            r_res_st  <= bmhpq_pkg::ST_OK;
        end
        if (i_cmd.err) r_res_st <= i_cmd.err_code;
        if (i_cmd.enq_init) begin
            r_at <= AW'(r_cnt);
            r_pr <= r_in_prio;
            r_ky <= r_in_key;
        end
        if (i_cmd.dq_load) begin
            r_res_key <= r_rd_a.key;
            r_res_pr  <= r_rd_a.prio;
            r_pr      <= r_rd_b.prio;
            r_ky      <= r_rd_b.key;
            r_at      <= '0;
        end
        if (i_cmd.ch_load) begin
            r_pr <= r_in_prio;
            r_ky <= r_rd_a.key;
            r_at <= AW'(r_pos);
        end
        if (i_cmd.up_move) r_at <= w_parent;
        if (i_cmd.dn_move) r_at <= w_sel_idx;
        if (i_cmd.out_load) begin
            r_o_key  <= r_res_key;
            r_o_pr   <= r_res_pr;
            r_o_st   <= r_res_st;
            r_o_held <= bmhpq_pkg::HELD_W'(r_cnt);
        end
    end

    always_comb begin
        o_flags.func      = r_func;
        o_flags.full      = (r_cnt == CW'(CAPACITY));
        o_flags.empty     = (r_cnt == '0);
        o_flags.pos_bad   = (PCW'(r_pos) >= PCW'(r_cnt));
        o_flags.at_root   = (r_at == '0);
        o_flags.up_stop   = (r_rd_a.prio >= r_pr);
        o_flags.child_out = (w_child >= w_cnt_x);
        o_flags.dn_stop   = (r_pr >= w_sel.prio);
        o_flags.pr_rise   = (r_in_prio > r_rd_a.prio);
        o_flags.pr_fall   = (r_in_prio < r_rd_a.prio);
    end

    assign o_key_out      = r_o_key;
    assign o_priority_out = r_o_pr;
    assign o_status       = r_o_st;
    assign o_entries_held = r_o_held;

endmodule

@@ hdl/binary_max_heap_priority_queue.sv @@
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue
// Max-heap of (priority, key) entries with enqueue, dequeue and change.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                 payload
//  request   in   i_in_valid / o_in_stall   i_func i_priority_in i_key_in i_position
//  result    out  o_out_valid / i_out_stall o_key_out o_priority_out o_status
//                                            o_entries_held
//
//  One request at a time: accept, decode, a load step for dequeue and change,
//  a registered memory read and then a compare and write per heap level
//  compared, a read where a walk reaches the root or a leaf, one final write,
//  and a load of the result register. Refused and no-op requests go from
//  decode straight to the result load, a same-priority change after its load.
//  Synchronous active-low reset empties the heap; slot contents are not cleared.
//  A stalled result waits in the output register; the next request is taken
//  once it has moved there.
// ----------------------------------------------------------------------------
module binary_max_heap_priority_queue #(
    parameter int CAPACITY = bmhpq_pkg::CAPACITY_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [bmhpq_pkg::FUNC_W-1:0] i_func,
    input  logic [bmhpq_pkg::PRIO_W-1:0] i_priority_in,
    input  logic [bmhpq_pkg::KEY_W-1:0]  i_key_in,
    input  logic [bmhpq_pkg::POS_W-1:0]  i_position,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [bmhpq_pkg::KEY_W-1:0]  o_key_out,
    output logic [bmhpq_pkg::PRIO_W-1:0] o_priority_out,
    output logic [bmhpq_pkg::STAT_W-1:0] o_status,
    output logic [bmhpq_pkg::HELD_W-1:0] o_entries_held
);

    bmhpq_pkg::t_cmd   w_cmd;
    bmhpq_pkg::t_flags w_flags;

    bmhpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_flags     (w_flags),
        .o_cmd       (w_cmd)
    );

    bmhpq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_flags        (w_flags),
        .i_func         (i_func),
        .i_priority_in  (i_priority_in),
        .i_key_in       (i_key_in),
        .i_position     (i_position),
        .o_key_out      (o_key_out),
        .o_priority_out (o_priority_out),
        .o_status       (o_status),
        .o_entries_held (o_entries_held)
    );

    // a taken request blocks the next one until its result is out
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted while another is in progress");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == bmhpq_pkg::ST_FULL)
            |-> (o_entries_held == bmhpq_pkg::HELD_W'(CAPACITY)))
        else $error("full status with heap not full");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == bmhpq_pkg::ST_EMPTY)
            |-> (o_entries_held == '0 && o_key_out == '0 && o_priority_out == '0))
        else $error("empty status with nonzero result");

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.up_move, w_cmd.dn_move, w_cmd.fin_write,
                  w_cmd.enq_init, w_cmd.dq_load}))
        else $error("conflicting datapath commands");

endmodule

@@ verif/binary_max_heap_priority_queue_checker.sv @@
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue_checker
// Watches the request and result channels of the heap, keeps its own copy of
// the heap contents, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module binary_max_heap_priority_queue_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic [bmhpq_pkg::FUNC_W-1:0] i_func,
    input  logic [bmhpq_pkg::PRIO_W-1:0] i_priority_in,
    input  logic [bmhpq_pkg::KEY_W-1:0]  i_key_in,
    input  logic [bmhpq_pkg::POS_W-1:0]  i_position,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic [bmhpq_pkg::KEY_W-1:0]  i_key_out,
    input  logic [bmhpq_pkg::PRIO_W-1:0] i_priority_out,
    input  logic [bmhpq_pkg::STAT_W-1:0] i_status,
    input  logic [bmhpq_pkg::HELD_W-1:0] i_entries_held,
    output int                           o_mismatches,
    output int                           o_pending,
    output int                           o_results
);

    localparam int HEAP_SLOTS = bmhpq_pkg::CAPACITY_DEF;

    typedef struct packed {
        logic [bmhpq_pkg::KEY_W-1:0]  key;
        logic [bmhpq_pkg::PRIO_W-1:0] prio;
        bmhpq_pkg::t_status           status;
        logic [bmhpq_pkg::HELD_W-1:0] held;
    } t_heap_result;

    logic [bmhpq_pkg::PRIO_W-1:0] heap_prio [HEAP_SLOTS];
    logic [bmhpq_pkg::KEY_W-1:0]  heap_key  [HEAP_SLOTS];
    int unsigned                  heap_fill;
    t_heap_result                 expected_results [$];
    t_heap_result                 due;

    // move the entry at 'at' toward the root while its parent is strictly smaller
    function automatic void float_entry_up(int unsigned at);
        logic [bmhpq_pkg::PRIO_W-1:0] pr;
        logic [bmhpq_pkg::KEY_W-1:0]  ky;
        int unsigned                  parent;
        pr = heap_prio[at];
        ky = heap_key[at];
        while (at > 0) begin
            parent = (at - 1) / 2;
            if (heap_prio[parent] >= pr) break;
            heap_prio[at] = heap_prio[parent];
            heap_key[at]  = heap_key[parent];
            at = parent;
        end
        heap_prio[at] = pr;
        heap_key[at]  = ky;
    endfunction

    // right child wins only when strictly larger; stop when not smaller than it
    function automatic void sink_entry_down(int unsigned at, int unsigned count);
        logic [bmhpq_pkg::PRIO_W-1:0] pr;
        logic [bmhpq_pkg::KEY_W-1:0]  ky;
        int unsigned                  child;
        pr = heap_prio[at];
        ky = heap_key[at];
        while (2 * at + 1 < count) begin
            child = 2 * at + 1;
            if (child + 1 < count && heap_prio[child] < heap_prio[child + 1]) child++;
            if (pr >= heap_prio[child]) break;
            heap_prio[at] = heap_prio[child];
            heap_key[at]  = heap_key[child];
            at = child;
        end
        heap_prio[at] = pr;
        heap_key[at]  = ky;
    endfunction

    function automatic t_heap_result apply_request(
        bmhpq_pkg::t_func fn, logic [bmhpq_pkg::PRIO_W-1:0] pr,
        logic [bmhpq_pkg::KEY_W-1:0] ky, logic [bmhpq_pkg::POS_W-1:0] pos);
        t_heap_result                 res;
        logic [bmhpq_pkg::PRIO_W-1:0] old;
        res = '{key: '0, prio: '0, status: bmhpq_pkg::ST_OK, held: '0};
        case (fn)
            bmhpq_pkg::FN_ENQ: begin
                if (heap_fill >= HEAP_SLOTS) begin
                    res.status = bmhpq_pkg::ST_FULL;
                end else begin
                    heap_prio[heap_fill] = pr;
                    heap_key[heap_fill]  = ky;
                    float_entry_up(heap_fill);
                    heap_fill++;
                end
            end
            bmhpq_pkg::FN_DEQ: begin
                if (heap_fill == 0) begin
                    res.status = bmhpq_pkg::ST_EMPTY;
                end else begin
                    res.key  = heap_key[0];
                    res.prio = heap_prio[0];
                    heap_fill--;
                    heap_prio[0] = heap_prio[heap_fill];
                    heap_key[0]  = heap_key[heap_fill];
                    sink_entry_down(0, heap_fill);
                end
            end
            bmhpq_pkg::FN_CHG: begin
                if (pos >= heap_fill) begin
                    res.status = bmhpq_pkg::ST_BADPOS;
                end else begin
                    old = heap_prio[pos];
                    heap_prio[pos] = pr;
                    if (pr > old) float_entry_up(pos);
                    else if (pr < old) sink_entry_down(pos, heap_fill);
                end
            end
            default: ;
        endcase
        res.held = heap_fill[bmhpq_pkg::HELD_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            heap_fill = 0;
            expected_results.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(apply_request(bmhpq_pkg::t_func'(i_func),
                                                         i_priority_in, i_key_in,
                                                         i_position));
            if (i_out_valid && !i_out_stall) begin
                o_results++;
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding: key %h prio %h status %0d",
                           i_key_out, i_priority_out, i_status);
                    o_mismatches++;
                end else begin
                    due = expected_results.pop_front();
                    if (i_key_out !== due.key) begin
                        $error("key_out: expected %h, got %h", due.key, i_key_out);
                        o_mismatches++;
                    end
                    if (i_priority_out !== due.prio) begin
                        $error("priority_out: expected %h, got %h", due.prio, i_priority_out);
                        o_mismatches++;
                    end
                    if (i_status !== due.status) begin
                        $error("status: expected %0d, got %0d", due.status, i_status);
                        o_mismatches++;
                    end
                    if (i_entries_held !== due.held) begin
                        $error("entries_held: expected %0d, got %0d", due.held,
                               i_entries_held);
                        o_mismatches++;
                    end
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

@@ verif/binary_max_heap_priority_queue_test.sv @@
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue_test
// Drives enqueue, dequeue, change-priority and no-op requests into the heap
// with random gaps and result back-pressure; the checker predicts and compares.
// ----------------------------------------------------------------------------
module binary_max_heap_priority_queue_test;

    localparam int HEAP_SLOTS   = bmhpq_pkg::CAPACITY_DEF;
    localparam int RANDOM_REQS  = 1500;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic [bmhpq_pkg::FUNC_W-1:0] func;
    logic [bmhpq_pkg::PRIO_W-1:0] priority_in;
    logic [bmhpq_pkg::KEY_W-1:0]  key_in;
    logic [bmhpq_pkg::POS_W-1:0]  position;
    logic                         out_valid;
    logic                         out_stall;
    logic [bmhpq_pkg::KEY_W-1:0]  key_out;
    logic [bmhpq_pkg::PRIO_W-1:0] priority_out;
    logic [bmhpq_pkg::STAT_W-1:0] status;
    logic [bmhpq_pkg::HELD_W-1:0] entries_held;

    int mismatches;
    int pending;
    int results;

    // sender-side bookkeeping, only touched by the stimulus process
    int  tx_fill = 0;
    bit  tx_steady = 1'b0;
    int  n_enq = 0, n_deq = 0, n_chg = 0, n_nop = 0;
    int  n_full = 0, n_empty = 0, n_badpos = 0;

    // receiver-side counters
    int rx_cycle = 0;
    int hold_left = 0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    binary_max_heap_priority_queue DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_func         (func),
        .i_priority_in  (priority_in),
        .i_key_in       (key_in),
        .i_position     (position),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_key_out      (key_out),
        .o_priority_out (priority_out),
        .o_status       (status),
        .o_entries_held (entries_held)
    );

    binary_max_heap_priority_queue_checker heap_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_func         (func),
        .i_priority_in  (priority_in),
        .i_key_in       (key_in),
        .i_position     (position),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_key_out      (key_out),
        .i_priority_out (priority_out),
        .i_status       (status),
        .i_entries_held (entries_held),
        .o_mismatches   (mismatches),
        .o_pending      (pending),
        .o_results      (results)
    );

    // result side: random stalls, one long hold that backs the heap up,
    // and a stretch with no stalls at all
    always @(posedge clk) begin
        rx_cycle <= rx_cycle + 1;
        if (!rst_n) begin
            out_stall <= 1'b0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (rx_cycle == 4000) begin
            out_stall <= 1'b1;
            hold_left <= 400;
        end else if (rx_cycle >= 10000 && rx_cycle < 16000) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(99) < 28);
        end
    end

    task automatic send_request(input bmhpq_pkg::t_func fn,
                                input logic [bmhpq_pkg::PRIO_W-1:0] pr,
                                input logic [bmhpq_pkg::KEY_W-1:0] ky,
                                input logic [bmhpq_pkg::POS_W-1:0] pos);
        while (!tx_steady && $urandom_range(99) < 28) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        func        <= fn;
        priority_in <= pr;
        key_in      <= ky;
        position    <= pos;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        case (fn)
            bmhpq_pkg::FN_ENQ: begin
                n_enq++;
                if (tx_fill >= HEAP_SLOTS) n_full++;
                else tx_fill++;
            end
            bmhpq_pkg::FN_DEQ: begin
                n_deq++;
                if (tx_fill == 0) n_empty++;
                else tx_fill--;
            end
            bmhpq_pkg::FN_CHG: begin
                n_chg++;
                if (pos >= tx_fill) n_badpos++;
            end
            default: n_nop++;
        endcase
    endtask

    function automatic logic [bmhpq_pkg::PRIO_W-1:0] pick_priority();
        int r;
        r = $urandom_range(99);
        if (r < 20) return bmhpq_pkg::PRIO_W'($urandom_range(3));  // dense ties
        if (r < 25) return '1;
        if (r < 28) return '0;
        return bmhpq_pkg::PRIO_W'($urandom);
    endfunction

    initial begin
        int                          seg_left;
        int                          seg_mode;
        int                          r;
        int                          enq_lim;
        int                          deq_lim;
        int                          idle_wait;
        bmhpq_pkg::t_func            fn;
        logic [bmhpq_pkg::POS_W-1:0] pos;

        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        func        <= bmhpq_pkg::FN_NOP;
        priority_in <= '0;
        key_in      <= '0;
        position    <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty heap: refusals and a no-op with busy fields
        send_request(bmhpq_pkg::FN_DEQ, 16'h1234, 16'h5678, 6'd0);
        send_request(bmhpq_pkg::FN_CHG, 16'hFFFF, 16'hFFFF, 6'd0);
        send_request(bmhpq_pkg::FN_CHG, 16'h0001, 16'h0000, 6'd63);
        send_request(bmhpq_pkg::FN_NOP, 16'hFFFF, 16'hFFFF, 6'd63);
        // field extremes and equal priorities
        send_request(bmhpq_pkg::FN_ENQ, 16'h0000, 16'h0000, 6'd0);
        send_request(bmhpq_pkg::FN_ENQ, 16'hFFFF, 16'hFFFF, 6'd63);
        send_request(bmhpq_pkg::FN_ENQ, 16'h8000, 16'h1234, 6'd0);
        send_request(bmhpq_pkg::FN_ENQ, 16'h8000, 16'h5678, 6'd0);
        send_request(bmhpq_pkg::FN_ENQ, 16'h8000, 16'hABCD, 6'd0);
        send_request(bmhpq_pkg::FN_NOP, 16'h0000, 16'h0000, 6'd0);
        // change to the same priority, a raise, a drop, one past the end
        send_request(bmhpq_pkg::FN_CHG, 16'hFFFF, 16'h0000, 6'd0);
        send_request(bmhpq_pkg::FN_CHG, 16'hFFFF, 16'h0000, 6'd4);
        send_request(bmhpq_pkg::FN_CHG, 16'h0000, 16'h0000, 6'd0);
        send_request(bmhpq_pkg::FN_CHG, 16'h7777, 16'h0000, 6'd5);
        send_request(bmhpq_pkg::FN_CHG, 16'h0000, 16'h0000, 6'd2);
        repeat (6) send_request(bmhpq_pkg::FN_DEQ, 16'h0000, 16'h0000, 6'd0);
        send_request(bmhpq_pkg::FN_ENQ, 16'h0005, 16'h00AA, 6'd0);
        send_request(bmhpq_pkg::FN_ENQ, 16'h0005, 16'h00BB, 6'd0);
        send_request(bmhpq_pkg::FN_DEQ, 16'h0000, 16'h0000, 6'd0);
        send_request(bmhpq_pkg::FN_DEQ, 16'h0000, 16'h0000, 6'd0);

        // random part in segments that lean toward filling, draining or mixing
        seg_left = 0;
        seg_mode = 0;
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(160, 80);
                seg_mode = $urandom_range(2);
            end
            seg_left--;
            tx_steady = (n >= 600 && n < 850);
            r = $urandom_range(99);
            case (seg_mode)
                0: begin
                    enq_lim = 70;
                    deq_lim = 85;
                end
                1: begin
                    enq_lim = 15;
                    deq_lim = 85;
                end
                default: begin
                    enq_lim = 40;
                    deq_lim = 70;
                end
            endcase
            if (r < enq_lim)      fn = bmhpq_pkg::FN_ENQ;
            else if (r < deq_lim) fn = bmhpq_pkg::FN_DEQ;
            else if (r < 97)      fn = bmhpq_pkg::FN_CHG;
            else                  fn = bmhpq_pkg::FN_NOP;
            if (fn == bmhpq_pkg::FN_CHG && tx_fill > 0 && $urandom_range(99) < 85)
                pos = bmhpq_pkg::POS_W'($urandom_range(tx_fill - 1));
            else
                pos = bmhpq_pkg::POS_W'($urandom_range(63));
            send_request(fn, pick_priority(), bmhpq_pkg::KEY_W'($urandom), pos);
        end
        in_valid  <= 1'b0;
        tx_steady = 1'b0;

        idle_wait = 0;
        while (pending != 0 && idle_wait < 5000) begin
            @(negedge clk);
            idle_wait++;
        end
        repeat (40) @(negedge clk);

        if (pending != 0) $error("%0d expected results never arrived", pending);
        $display("Sent %0d enqueue, %0d dequeue, %0d change and %0d no-op requests;",
                 n_enq, n_deq, n_chg, n_nop);
        $display("%0d results compared; refused %0d full, %0d empty, %0d out of range.",
                 results, n_full, n_empty, n_badpos);
        if (mismatches == 0 && pending == 0)
            $display("binary_max_heap_priority_queue test passed");
        else
            $display("binary_max_heap_priority_queue test failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("binary_max_heap_priority_queue test failed");
        $finish;
    end

endmodule
